// ===== design/scp_pkg.sv =====
// Shared types and constants of the stage cycle profiler.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

   // Field widths of a request and a response.
   localparam int unsigned CYC_W     = 64;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned STAGE_W   = 4;
   localparam int unsigned DEPTH_W   = 8;
   localparam int unsigned STG_CMP_W = STAGE_W + 1;

   typedef logic [CYC_W-1:0]   cyc_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [STAGE_W-1:0] stage_type;
   typedef logic [DEPTH_W-1:0] depth_type;

   // Request kinds.
   localparam kind_type KIND_SAMPLE = 2'd0;
   localparam kind_type KIND_OPEN   = 2'd1;
   localparam kind_type KIND_CLOSE  = 2'd2;
   localparam kind_type KIND_READ   = 2'd3;

   localparam depth_type DEPTH_MAX = '1;

   // Register port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   // Word index of the enable register.
   localparam logic CSR_IDX_ENABLE = 1'b0;

   // One entry of the per-stage store.
   typedef struct packed {
      cyc_type sum;
      cyc_type count;
      cyc_type maximum;
   } entry_type;

   // Figures reported with every response.
   typedef struct packed {
      cyc_type stage_cycle_sum;
      cyc_type stage_sample_count;
      cyc_type stage_max_cycles;
      cyc_type all_stage_cycles;
      cyc_type outer_cycle_sum;
      cyc_type outer_window_count;
      cyc_type outer_max_cycles;
      cyc_type residual_cycle_sum;
      cyc_type residual_clamps;
      cyc_type reversed_samples;
      logic    profile_active;
      logic    window_open;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/scp_stream_if.sv =====
// Request and response channel interfaces of the stage cycle profiler.
// Depends on scp_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface scp_req_if;
   import scp_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   stage_type stage;
   cyc_type   start_stamp;
   cyc_type   end_stamp;

   modport source (output valid, kind, stage, start_stamp, end_stamp, input ready);
   modport sink   (input valid, kind, stage, start_stamp, end_stamp, output ready);
endinterface

interface scp_rsp_if;
   import scp_pkg::*;

   logic    valid;
   logic    ready;
   cyc_type stage_cycle_sum;
   cyc_type stage_sample_count;
   cyc_type stage_max_cycles;
   cyc_type all_stage_cycles;
   cyc_type outer_cycle_sum;
   cyc_type outer_window_count;
   cyc_type outer_max_cycles;
   cyc_type residual_cycle_sum;
   cyc_type residual_clamps;
   cyc_type reversed_samples;
   logic    profile_active;
   logic    window_open;

   modport source (
      output valid, stage_cycle_sum, stage_sample_count, stage_max_cycles,
             all_stage_cycles, outer_cycle_sum, outer_window_count, outer_max_cycles,
             residual_cycle_sum, residual_clamps, reversed_samples, profile_active,
             window_open,
      input  ready
   );
   modport sink (
      input  valid, stage_cycle_sum, stage_sample_count, stage_max_cycles,
             all_stage_cycles, outer_cycle_sum, outer_window_count, outer_max_cycles,
             residual_cycle_sum, residual_clamps, reversed_samples, profile_active,
             window_open,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/scp_csr.sv =====
// Register port of the stage cycle profiler: holds the profile enable bit.
// Depends on scp_pkg for the address and data types.
`timescale 1ns / 1ps
`default_nettype none

module scp_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire scp_pkg::csr_addr_type paddr,
   input  wire scp_pkg::csr_data_type pwdata,
   output scp_pkg::csr_data_type      prdata,
   output logic                      pready,
   output logic                      profile_enable
);
   import scp_pkg::*;

   logic enable_ff;
   logic enable_in;
   logic word_idx;
   logic wr_access;

   // Registers sit on 32-bit words; the top address bit picks the word.
   assign word_idx  = paddr[CSR_ADDR_W-1];
   assign wr_access = psel && penable && pwrite;

   // Enable register update.
   always_comb begin
      enable_in = enable_ff;
      if (wr_access && (word_idx == CSR_IDX_ENABLE)) begin
         enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // Read data; words beyond the register list read as zero.
   always_comb begin
      prdata = '0;
      if (word_idx == CSR_IDX_ENABLE) begin
         prdata[0] = enable_ff;
      end
   end

   assign pready         = 1'b1;
   assign profile_enable = enable_ff;

endmodule

`default_nettype wire

// ===== design/stage_cycle_profiler.sv =====
// Top level of the stage cycle profiler: per-stage store, window logic and
// response register. Depends on scp_pkg, scp_stream_if and scp_csr.
//
// Usage:
// Requests arrive on req_chan (kind, stage, start_stamp, end_stamp) and are
// taken when valid and ready are both high. Each request gives exactly one
// response on rsp_chan, in request order, carrying the figures after the
// request's update: per-stage sum, count and maximum of the addressed stage
// (zero for a stage index at or above NUM_STAGES), and the global totals.
// A stage sample, an outer window open or close updates the figures only
// while profile_enable is set; a read, or any kind while disabled, reports.
// A request passes the work stage, then the response register. One request is
// taken every cycle while the receiver takes responses: the per-stage store
// is read when a request is taken and written back as it leaves the work
// stage, with the write forwarded to a following request on the same stage,
// so its single read and write port sets the rate. When the receiver stalls,
// the response register holds and the block keeps taking requests until its
// one internal stage is also full; then req ready falls. Synchronous reset
// clears all figures, the window depth and the enable bit; the store has a
// valid bit per entry, so no clearing pass runs. profile_enable is written
// through the APB-style port at byte address 0.
`timescale 1ns / 1ps
`default_nettype none

module stage_cycle_profiler #(
   parameter int unsigned NUM_STAGES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   scp_req_if.sink                    req_chan,
   scp_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire scp_pkg::csr_addr_type paddr,
   input  wire scp_pkg::csr_data_type pwdata,
   output scp_pkg::csr_data_type      prdata,
   output logic                       pready
);
   import scp_pkg::*;

   localparam int unsigned IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   logic profile_enable;

   // Register port.
   scp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .profile_enable (profile_enable)
   );

   // Handshake and index decode at acceptance.
   logic             req_accept;
   logic             s1_adv;
   logic             stage_ok;
   logic [IDX_W-1:0] rd_addr;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign stage_ok   = {1'b0, req_chan.stage} < STG_CMP_W'(NUM_STAGES);
   assign rd_addr    = stage_ok ? req_chan.stage[IDX_W-1:0] : '0;

   // Work stage registers.
   logic             s1_valid_ff;
   logic             s1_valid_in;
   kind_type         s1_kind_ff;
   logic             s1_stage_ok_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   cyc_type          s1_start_ff;
   cyc_type          s1_end_ff;

   // Response register.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_kind_ff     <= req_chan.kind;
         s1_stage_ok_ff <= stage_ok;
         s1_idx_ff      <= rd_addr;
         s1_start_ff    <= req_chan.start_stamp;
         s1_end_ff      <= req_chan.end_stamp;
      end
   end

   // Per-stage store: one synchronous read port, one write port.
   entry_type             stage_mem [NUM_STAGES];
   entry_type             rd_data_ff;
   logic [NUM_STAGES-1:0] entry_vld_ff;
   logic                  rd_vld_ff;
   logic                  fwd_hit_ff;
   entry_type             fwd_data_ff;
   logic                  mem_we;
   entry_type             new_entry;
   entry_type             cur_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stage_mem[s1_idx_ff] <= new_entry;
      end
      if (req_accept) begin
         rd_data_ff  <= stage_mem[rd_addr];
         fwd_data_ff <= new_entry;
      end
   end

   // Entry valid bits and the forwarding flag for a write that lands
   // at the same edge as the read of the following request.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            entry_vld_ff[s1_idx_ff] <= 1'b1;
         end
         if (req_accept) begin
            rd_vld_ff  <= entry_vld_ff[rd_addr];
            fwd_hit_ff <= mem_we && (s1_idx_ff == rd_addr);
         end
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         cur_entry = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = '0;
      end
   end

   // Global figures.
   cyc_type   grand_total_ff, grand_total_in;
   cyc_type   outer_sum_ff, outer_sum_in;
   cyc_type   outer_count_ff, outer_count_in;
   cyc_type   outer_max_ff, outer_max_in;
   cyc_type   resid_sum_ff, resid_sum_in;
   cyc_type   resid_clamp_ff, resid_clamp_in;
   cyc_type   reversed_ff, reversed_in;
   logic      seen_ff, seen_in;
   depth_type nest_depth_ff, nest_depth_in;
   cyc_type   win_start_ff, win_start_in;
   cyc_type   total_open_ff, total_open_in;

   logic    upd_en;
   logic    smp_rev;
   cyc_type smp_dur;
   logic    win_rev;
   cyc_type win_dur;
   cyc_type covered_cycles;

   assign upd_en  = s1_adv && profile_enable;
   assign smp_rev = s1_end_ff < s1_start_ff;
   assign smp_dur = s1_end_ff - s1_start_ff;
   assign win_rev = s1_end_ff < win_start_ff;
   assign win_dur = s1_end_ff - win_start_ff;
   assign covered_cycles = (grand_total_ff >= total_open_ff) ? (grand_total_ff - total_open_ff)
                                                             : '0;
   assign mem_we  = upd_en && (s1_kind_ff == KIND_SAMPLE) && s1_stage_ok_ff;

   // New stage entry for a sample.
   always_comb begin
      new_entry       = cur_entry;
      new_entry.count = cur_entry.count + 64'd1;
      if (!smp_rev) begin
         new_entry.sum = cur_entry.sum + smp_dur;
         if (smp_dur > cur_entry.maximum) begin
            new_entry.maximum = smp_dur;
         end
      end
   end

   // Global update for each kind.
   always_comb begin
      grand_total_in = grand_total_ff;
      outer_sum_in   = outer_sum_ff;
      outer_count_in = outer_count_ff;
      outer_max_in   = outer_max_ff;
      resid_sum_in   = resid_sum_ff;
      resid_clamp_in = resid_clamp_ff;
      reversed_in    = reversed_ff;
      seen_in        = seen_ff;
      nest_depth_in  = nest_depth_ff;
      win_start_in   = win_start_ff;
      total_open_in  = total_open_ff;
      if (upd_en) begin
         unique case (s1_kind_ff)
            KIND_SAMPLE: begin
               if (s1_stage_ok_ff) begin
                  seen_in = 1'b1;
                  if (smp_rev) begin
                     reversed_in = reversed_ff + 64'd1;
                  end else begin
                     grand_total_in = grand_total_ff + smp_dur;
                  end
               end
            end
            KIND_OPEN: begin
               if (nest_depth_ff == '0) begin
                  win_start_in  = s1_start_ff;
                  total_open_in = grand_total_ff;
                  nest_depth_in = depth_type'(1);
               end else if (nest_depth_ff != DEPTH_MAX) begin
                  nest_depth_in = nest_depth_ff + depth_type'(1);
               end
            end
            KIND_CLOSE: begin
               if (nest_depth_ff == depth_type'(1)) begin
                  // Outermost close records the window.
                  nest_depth_in  = '0;
                  seen_in        = 1'b1;
                  outer_count_in = outer_count_ff + 64'd1;
                  if (win_rev) begin
                     reversed_in = reversed_ff + 64'd1;
                  end else begin
                     outer_sum_in = outer_sum_ff + win_dur;
                     if (win_dur > outer_max_ff) begin
                        outer_max_in = win_dur;
                     end
                     if (win_dur < covered_cycles) begin
                        resid_clamp_in = resid_clamp_ff + 64'd1;
                     end else begin
                        resid_sum_in = resid_sum_ff + (win_dur - covered_cycles);
                     end
                  end
               end else if (nest_depth_ff != '0) begin
                  nest_depth_in = nest_depth_ff - depth_type'(1);
               end
            end
            KIND_READ: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grand_total_ff <= '0;
         outer_sum_ff   <= '0;
         outer_count_ff <= '0;
         outer_max_ff   <= '0;
         resid_sum_ff   <= '0;
         resid_clamp_ff <= '0;
         reversed_ff    <= '0;
         seen_ff        <= 1'b0;
         nest_depth_ff  <= '0;
         win_start_ff   <= '0;
         total_open_ff  <= '0;
      end else begin
         grand_total_ff <= grand_total_in;
         outer_sum_ff   <= outer_sum_in;
         outer_count_ff <= outer_count_in;
         outer_max_ff   <= outer_max_in;
         resid_sum_ff   <= resid_sum_in;
         resid_clamp_ff <= resid_clamp_in;
         reversed_ff    <= reversed_in;
         seen_ff        <= seen_in;
         nest_depth_ff  <= nest_depth_in;
         win_start_ff   <= win_start_in;
         total_open_ff  <= total_open_in;
      end
   end

   // Response assembly with the figures after the update.
   always_comb begin
      entry_type shown;
      shown = mem_we ? new_entry : cur_entry;
      if (!s1_stage_ok_ff) begin
         shown = '0;
      end
      rsp_in.stage_cycle_sum    = shown.sum;
      rsp_in.stage_sample_count = shown.count;
      rsp_in.stage_max_cycles   = shown.maximum;
      rsp_in.all_stage_cycles   = grand_total_in;
      rsp_in.outer_cycle_sum    = outer_sum_in;
      rsp_in.outer_window_count = outer_count_in;
      rsp_in.outer_max_cycles   = outer_max_in;
      rsp_in.residual_cycle_sum = resid_sum_in;
      rsp_in.residual_clamps    = resid_clamp_in;
      rsp_in.reversed_samples   = reversed_in;
      rsp_in.profile_active     = seen_in;
      rsp_in.window_open        = (nest_depth_in != '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.stage_cycle_sum    = rsp_ff.stage_cycle_sum;
   assign rsp_chan.stage_sample_count = rsp_ff.stage_sample_count;
   assign rsp_chan.stage_max_cycles   = rsp_ff.stage_max_cycles;
   assign rsp_chan.all_stage_cycles   = rsp_ff.all_stage_cycles;
   assign rsp_chan.outer_cycle_sum    = rsp_ff.outer_cycle_sum;
   assign rsp_chan.outer_window_count = rsp_ff.outer_window_count;
   assign rsp_chan.outer_max_cycles   = rsp_ff.outer_max_cycles;
   assign rsp_chan.residual_cycle_sum = rsp_ff.residual_cycle_sum;
   assign rsp_chan.residual_clamps    = rsp_ff.residual_clamps;
   assign rsp_chan.reversed_samples   = rsp_ff.reversed_samples;
   assign rsp_chan.profile_active     = rsp_ff.profile_active;
   assign rsp_chan.window_open        = rsp_ff.window_open;

`ifndef SYNTHESIS
   // A full work stage behind a stalled response must block new requests.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while the pipeline is full and stalled");

   // Figures only move when a request leaves the work stage.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(s1_adv) |-> $stable(grand_total_ff) && $stable(outer_count_ff))
      else $error("global figures changed without a request completing");

   // At most one reversed sample or window is counted per request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (reversed_ff == $past(reversed_ff))
                        || (reversed_ff == $past(reversed_ff) + 64'd1))
      else $error("reversed count stepped by more than one");

   // At most one window closes per request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (outer_count_ff == $past(outer_count_ff))
                        || (outer_count_ff == $past(outer_count_ff) + 64'd1))
      else $error("outer window count stepped by more than one");

   // Reset leaves no response pending and no window open.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid_ff && (nest_depth_ff == '0) && !s1_valid_ff)
      else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire
